>>> src/mfsk_pkg.sv
// ----------------------------------------------------------------------------
// mfsk_pkg
// Shared constants, types and twiddle tables of the MFSK early/late demodulator.
// ----------------------------------------------------------------------------
package mfsk_pkg;

    localparam int N          = 64;
    localparam int HALF_BINS  = N / 2;
    localparam int SAMPLE_W   = 16;
    localparam int CNT_W      = $clog2(N);
    localparam int BIN_W      = $clog2(HALF_BINS);
    localparam int GATE_W     = CNT_W + 1;
    localparam int TW_W       = 16;
    localparam int PROD_W     = SAMPLE_W + TW_W;
    localparam int ACC_W      = SAMPLE_W + CNT_W + 1;
    localparam int MAG_W      = ACC_W - 1;
    localparam int ENERGY_W   = 2 * MAG_W + 2;
    localparam int TOTAL_W    = ENERGY_W + BIN_W;
    localparam int ROOT_W     = ENERGY_W / 2;
    localparam int CAR_W      = 5;
    localparam int BPS_W      = 3;
    localparam int SYM_W      = 4;
    localparam int MAX_BITS   = 4;
    localparam int NOISE_FACTOR = 3;
    localparam int GATE_STEP  = 2;
    localparam int TOL_RECIP  = 20;
    localparam int CAR_RESET  = 8;
    localparam int BPS_RESET  = 2;

    localparam logic REG_CARRIER = 1'b0;
    localparam logic REG_BPS     = 1'b1;

    typedef enum logic [1:0] {
        ST_SYMBOL  = 2'd0,
        ST_NOISE   = 2'd1,
        ST_CARRIER = 2'd2,
        ST_RANGE   = 2'd3
    } status_code_t;

    typedef enum logic [3:0] {
        S_IDLE,
        S_MAC,
        S_DRAIN,
        S_SQUARE,
        S_BIN,
        S_LATE_SAVE,
        S_SQRT_L_GO,
        S_SQRT_L_WAIT,
        S_SQRT_E_GO,
        S_SQRT_E_WAIT,
        S_DECIDE,
        S_COPY,
        S_COPY_DRAIN
    } ctrl_state_t;

    typedef struct packed {
        logic wr_sample;
        logic pass_start;
        logic mac_issue;
        logic square;
        logic bin_done;
        logic late_save;
        logic sqrt_start;
        logic sqrt_sel;
        logic decide;
        logic copy_issue;
    } ctrl_cmd_t;

    typedef struct packed {
        logic last_sample;
        logic out_pending;
        logic n_last;
        logic pipe_busy;
        logic k_last;
        logic pass_early;
        logic sqrt_done;
        logic gate_zero;
        logic copy_last;
    } dp_status_t;

    typedef logic [N-1:0][TW_W-1:0] tw_tab_t;

    function automatic longint quarter_sine(longint x);
        longint x2;
        longint t;
        x2 = (x * x) >>> 15;
        t  = (2369 * x2) >>> 15;
        t  = 21073 - t;
        t  = (x2 * t) >>> 15;
        t  = 51472 - t;
        t  = (x * t) >>> 15;
        if (t > 32767) t = 32767;
        return t;
    endfunction

    // sel_sin picks the sine table, else cosine
    function automatic tw_tab_t build_tw(bit sel_sin);
        tw_tab_t tab;
        longint  turn;
        longint  quad;
        longint  x;
        longint  a;
        longint  b;
        longint  c;
        longint  s;
        for (int p = 0; p < N; p++) begin
            turn = (longint'(p) * 65536) / N;
            quad = (turn >>> 14) & 3;
            x    = (turn & 16383) << 1;
            a    = quarter_sine(x);
            b    = quarter_sine(32768 - x);
            case (quad)
                0: begin s = a;  c = b;  end
                1: begin s = b;  c = -a; end
                2: begin s = -a; c = -b; end
                default: begin s = -b; c = a; end
            endcase
            tab[p] = sel_sin ? TW_W'(s) : TW_W'(c);
        end
        return tab;
    endfunction

    localparam tw_tab_t COS_TAB = build_tw(1'b0);
    localparam tw_tab_t SIN_TAB = build_tw(1'b1);

endpackage

>>> src/mfsk_demod_early_late_gate.sv
// ----------------------------------------------------------------------------
// mfsk_demod_early_late_gate
// MFSK demodulator with early/late symbol-timing gate and APB register port.
// ----------------------------------------------------------------------------
// Samples are taken one per cycle while the block is idle, until a block of 64
// is complete; the last sample of a block is held off while the previous result
// is still pending. The block then runs two 32-bin DFTs (late window, then early
// window) on one complex multiply-accumulate unit, then two square roots, the
// decision and a copy of up to 64 tail samples through the sample memory port.
// No sample is taken during this; the result transfer is offered once the
// decision is made. Registers: carrier_bin at 0x0, tone_bits at 0x4; write them
// only while the block is idle.
module mfsk_demod_early_late_gate
    import mfsk_pkg::*;
(
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                s_valid,
    output logic                s_ready,
    input  logic [SAMPLE_W-1:0] s_sample,
    output logic                m_valid,
    input  logic                m_ready,
    output logic [SYM_W-1:0]    m_symbol_value,
    output logic [1:0]          m_status,
    output logic [GATE_W-1:0]   m_gate_position,
    input  logic                psel,
    input  logic                penable,
    input  logic                pwrite,
    input  logic [2:0]          paddr,
    input  logic [31:0]         pwdata,
    output logic [31:0]         prdata,
    output logic                pready
);

    logic [CAR_W-1:0] carrier_reg;
    logic [BPS_W-1:0] bps_reg;
    ctrl_cmd_t        cmd;
    dp_status_t       status;

    assign pready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            carrier_reg <= CAR_W'(CAR_RESET);
            bps_reg     <= BPS_W'(BPS_RESET);
        end else if (psel && penable && pwrite) begin
            if (paddr[2] == REG_CARRIER) carrier_reg <= pwdata[CAR_W-1:0];
            else bps_reg <= pwdata[BPS_W-1:0];
        end
    end

    assign prdata = (paddr[2] == REG_BPS) ? 32'(bps_reg) : 32'(carrier_reg);

    mfsk_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .status  (status),
        .cmd     (cmd)
    );

    mfsk_dp u_dp (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .cmd             (cmd),
        .status          (status),
        .s_sample        (s_sample),
        .carrier_bin     (carrier_reg),
        .tone_bits       (bps_reg),
        .m_valid         (m_valid),
        .m_ready         (m_ready),
        .m_symbol_value  (m_symbol_value),
        .m_status        (m_status),
        .m_gate_position (m_gate_position)
    );

endmodule

>>> src/mfsk_isqrt.sv
// ----------------------------------------------------------------------------
// mfsk_isqrt
// Floor square root of a bin energy, one result bit per cycle.
// ----------------------------------------------------------------------------
module mfsk_isqrt
    import mfsk_pkg::*;
(
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                start,
    input  logic [ENERGY_W-1:0] operand,
    output logic                done,
    output logic [ROOT_W-1:0]   root
);

    logic [ENERGY_W-1:0] rem_reg, rem_next;
    logic [ENERGY_W-1:0] res_reg, res_next;
    logic [ENERGY_W-1:0] bit_reg, bit_next;
    logic                busy_reg, busy_next;
    logic                done_reg, done_next;
    logic [ENERGY_W-1:0] trial;

    assign trial = res_reg + bit_reg;

    always_comb begin
        rem_next  = rem_reg;
        res_next  = res_reg;
        bit_next  = bit_reg;
        busy_next = busy_reg;
        done_next = 1'b0;
        if (start) begin
            rem_next  = operand;
            res_next  = '0;
            bit_next  = ENERGY_W'(1) << (ENERGY_W - 2);
            busy_next = 1'b1;
        end else if (busy_reg) begin
            if (rem_reg >= trial) begin
                rem_next = rem_reg - trial;
                res_next = (res_reg >> 1) + bit_reg;
            end else begin
                res_next = res_reg >> 1;
            end
            bit_next = bit_reg >> 2;
            if (bit_reg == ENERGY_W'(1)) begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end else begin
            busy_reg <= busy_next;
            done_reg <= done_next;
        end
        rem_reg <= rem_next;
        res_reg <= res_next;
        bit_reg <= bit_next;
    end

    assign done = done_reg;
    assign root = res_reg[ROOT_W-1:0];

    a_start_idle: assert property (@(posedge aclk) disable iff (!aresetn)
        start |-> !busy_reg) else $error("root start while busy");

endmodule

>>> src/mfsk_dp.sv
// ----------------------------------------------------------------------------
// mfsk_dp
// Datapath: sample and tail memories, DFT multiply-accumulate, peak search,
// gate decision and result register.
// ----------------------------------------------------------------------------
module mfsk_dp
    import mfsk_pkg::*;
(
    input  logic                aclk,
    input  logic                aresetn,
    input  ctrl_cmd_t           cmd,
    output dp_status_t          status,
    input  logic [SAMPLE_W-1:0] s_sample,
    input  logic [CAR_W-1:0]    carrier_bin,
    input  logic [BPS_W-1:0]    tone_bits,
    output logic                m_valid,
    input  logic                m_ready,
    output logic [SYM_W-1:0]    m_symbol_value,
    output logic [1:0]          m_status,
    output logic [GATE_W-1:0]   m_gate_position
);

    logic [SAMPLE_W-1:0] blk_mem [N];
    logic [SAMPLE_W-1:0] tail_mem [N];
    logic [N-1:0]        tail_vld_reg;
    logic [SAMPLE_W-1:0] blk_q, tail_q;

    logic [CNT_W-1:0]    cnt_reg;
    logic [CNT_W-1:0]    n_reg;
    logic [BIN_W-1:0]    k_reg;
    logic                pass_early_reg;
    logic [GATE_W-1:0]   gate_reg;

    logic [CNT_W-1:0]    blk_raddr;
    logic [BIN_W+CNT_W-1:0] kn;
    logic [CNT_W-1:0]    phase;

    logic                v1_reg, v2_reg;
    logic                sel_tail_reg, tail_ok_reg;
    logic signed [TW_W-1:0]   cos_reg, sin_reg;
    logic signed [SAMPLE_W-1:0] smp;
    logic signed [PROD_W-1:0] prod_re_reg, prod_im_reg;
    logic signed [ACC_W-1:0]  acc_re_reg, acc_im_reg;
    logic [MAG_W-1:0]    mag_re, mag_im;
    logic [2*MAG_W-1:0]  sq_re_reg, sq_im_reg;
    logic [ENERGY_W-1:0] energy;

    logic [ENERGY_W-1:0] best_reg, peak_l_reg;
    logic [BIN_W-1:0]    best_bin_reg, bin_l_reg;
    logic [TOTAL_W-1:0]  total_reg;
    logic                clear_acc;

    logic                cp_v_reg;
    logic [CNT_W-1:0]    cp_idx_reg;

    logic                root_sel_reg;
    logic                root_done;
    logic [ROOT_W-1:0]   root;
    logic [ROOT_W-1:0]   ml_reg, me_reg;

    logic [BPS_W-1:0]    bits;
    logic [SYM_W:0]      tones;
    logic [SYM_W-1:0]    half;
    logic [CAR_W-1:0]    lo;
    logic [CAR_W:0]      hi_raw, hi;
    logic                in_range;

    logic                noise;
    logic [ROOT_W-1:0]   diff;
    logic signed [GATE_W:0] g_step, g_new;
    logic signed [GATE_W:0] offset;
    logic signed [GATE_W:0] sym_idx;
    status_code_t        code;
    logic [SYM_W-1:0]    sym;

    logic                m_valid_reg;
    logic [SYM_W-1:0]    sym_reg;
    logic [1:0]          code_reg;

    // sample memory, read port shared by both DFT passes and the tail copy
    assign blk_raddr = cmd.copy_issue ? CNT_W'(GATE_W'(N) - gate_reg + GATE_W'(n_reg))
                     : (pass_early_reg ? n_reg - gate_reg[CNT_W-1:0] : n_reg);

    always_ff @(posedge aclk) begin
        if (cmd.wr_sample) blk_mem[cnt_reg] <= s_sample;
        blk_q <= blk_mem[blk_raddr];
    end

    always_ff @(posedge aclk) begin
        if (cp_v_reg) tail_mem[cp_idx_reg] <= blk_q;
        tail_q <= tail_mem[n_reg];
    end

    assign kn    = BIN_W'(k_reg) * (BIN_W+CNT_W)'(n_reg);
    assign phase = kn[CNT_W-1:0];

    // stage 1: operands and twiddles
    always_ff @(posedge aclk) begin
        sel_tail_reg <= pass_early_reg && (GATE_W'(n_reg) < gate_reg);
        tail_ok_reg  <= tail_vld_reg[n_reg];
        cos_reg      <= COS_TAB[phase];
        sin_reg      <= SIN_TAB[phase];
    end

    assign smp = sel_tail_reg ? (tail_ok_reg ? tail_q : '0) : blk_q;

    // stage 2: products
    always_ff @(posedge aclk) begin
        prod_re_reg <= smp * cos_reg;
        prod_im_reg <= smp * sin_reg;
    end

    assign clear_acc = cmd.pass_start | cmd.bin_done | cmd.late_save;

    // stage 3: floor-scaled accumulate
    always_ff @(posedge aclk) begin
        if (clear_acc) begin
            acc_re_reg <= '0;
            acc_im_reg <= '0;
        end else if (v2_reg) begin
            acc_re_reg <= acc_re_reg + ACC_W'(prod_re_reg >>> 15);
            acc_im_reg <= acc_im_reg + ACC_W'(prod_im_reg >>> 15);
        end
    end

    assign mag_re = acc_re_reg[ACC_W-1] ? MAG_W'(-acc_re_reg) : MAG_W'(acc_re_reg);
    assign mag_im = acc_im_reg[ACC_W-1] ? MAG_W'(-acc_im_reg) : MAG_W'(acc_im_reg);

    always_ff @(posedge aclk) begin
        if (cmd.square) begin
            sq_re_reg <= mag_re * mag_re;
            sq_im_reg <= mag_im * mag_im;
        end
    end

    assign energy = ENERGY_W'(sq_re_reg) + ENERGY_W'(sq_im_reg);

    // search range around the carrier
    assign bits   = (tone_bits > BPS_W'(MAX_BITS)) ? BPS_W'(MAX_BITS) : tone_bits;
    assign tones  = (SYM_W+1)'(1) << bits;
    assign half   = tones[SYM_W:1];
    assign lo     = (carrier_bin > CAR_W'(half)) ? carrier_bin - CAR_W'(half) : '0;
    assign hi_raw = (CAR_W+1)'(carrier_bin) + (CAR_W+1)'(half);
    assign hi     = (hi_raw > (CAR_W+1)'(HALF_BINS - 1)) ? (CAR_W+1)'(HALF_BINS - 1) : hi_raw;
    assign in_range = (CAR_W'(k_reg) >= lo) && ((CAR_W+1)'(k_reg) <= hi);

    // control counters, pass flag, peak search
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cnt_reg        <= '0;
            n_reg          <= '0;
            k_reg          <= '0;
            pass_early_reg <= 1'b0;
            v1_reg         <= 1'b0;
            v2_reg         <= 1'b0;
            cp_v_reg       <= 1'b0;
            tail_vld_reg   <= '0;
        end else begin
            v1_reg   <= cmd.mac_issue;
            v2_reg   <= v1_reg;
            cp_v_reg <= cmd.copy_issue;
            if (cmd.wr_sample) cnt_reg <= cnt_reg + CNT_W'(1);
            if (cmd.mac_issue || cmd.copy_issue) begin
                n_reg <= n_reg + CNT_W'(1);
            end else if (clear_acc) begin
                n_reg <= '0;
            end
            if (cmd.pass_start || cmd.late_save) begin
                k_reg <= '0;
            end else if (cmd.bin_done) begin
                k_reg <= k_reg + BIN_W'(1);
            end
            if (cmd.pass_start) pass_early_reg <= 1'b0;
            else if (cmd.late_save) pass_early_reg <= 1'b1;
            if (cp_v_reg) tail_vld_reg[cp_idx_reg] <= 1'b1;
        end
        cp_idx_reg <= n_reg;
    end

    always_ff @(posedge aclk) begin
        if (cmd.pass_start || cmd.late_save) begin
            best_reg     <= '0;
            best_bin_reg <= '0;
            total_reg    <= '0;
        end else if (cmd.bin_done) begin
            total_reg <= total_reg + TOTAL_W'(energy);
            if (in_range && energy > best_reg) begin
                best_reg     <= energy;
                best_bin_reg <= k_reg;
            end
        end
        if (cmd.late_save) begin
            peak_l_reg <= best_reg;
            bin_l_reg  <= best_bin_reg;
        end
    end

    // magnitudes for the tolerance test
    mfsk_isqrt u_isqrt (
        .aclk    (aclk),
        .aresetn (aresetn),
        .start   (cmd.sqrt_start),
        .operand (cmd.sqrt_sel ? best_reg : peak_l_reg),
        .done    (root_done),
        .root    (root)
    );

    always_ff @(posedge aclk) begin
        if (cmd.sqrt_start) root_sel_reg <= cmd.sqrt_sel;
        if (root_done) begin
            if (root_sel_reg) me_reg <= root;
            else ml_reg <= root;
        end
    end

    // decision on the early window; gate step from the late and early magnitudes
    assign noise = (TOTAL_W+2)'(best_reg) * (TOTAL_W+2)'(HALF_BINS)
                 < (TOTAL_W+2)'(total_reg) * (TOTAL_W+2)'(NOISE_FACTOR);
    assign diff  = (ml_reg > me_reg) ? ml_reg - me_reg : me_reg - ml_reg;

    always_comb begin
        g_step = $signed({1'b0, gate_reg});
        if ((ROOT_W+5)'(diff) * (ROOT_W+5)'(TOL_RECIP) < (ROOT_W+5)'(me_reg)) begin
            g_step = $signed({1'b0, gate_reg});
        end else if (ml_reg > me_reg) begin
            g_step = $signed({1'b0, gate_reg}) + (GATE_W+1)'(GATE_STEP);
        end else begin
            g_step = $signed({1'b0, gate_reg}) - (GATE_W+1)'(GATE_STEP);
        end
        if (g_step > $signed((GATE_W+1)'(N))) g_step = (GATE_W+1)'(N - N / 2);
        if (g_step < 0) g_step = (GATE_W+1)'(N / 2);
        g_new = $signed({1'b0, gate_reg});
        if (noise) g_new = (GATE_W+1)'(N);
        else if (best_bin_reg != bin_l_reg) g_new = g_step;
    end

    always_comb begin
        offset  = $signed((GATE_W+1)'(best_bin_reg)) - $signed((GATE_W+1)'(carrier_bin));
        sym_idx = (offset > 0) ? (offset <<< 1) - (GATE_W+1)'(1)
                               : ((-offset) <<< 1) - (GATE_W+1)'(2);
        sym     = '0;
        if (noise) begin
            code = ST_NOISE;
        end else if (offset == 0) begin
            code = ST_CARRIER;
        end else if (sym_idx >= $signed((GATE_W+1)'(tones))) begin
            code = ST_RANGE;
        end else begin
            code = ST_SYMBOL;
            sym  = sym_idx[SYM_W-1:0];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            gate_reg    <= GATE_W'(N - 1);
            m_valid_reg <= 1'b0;
        end else begin
            if (cmd.decide) begin
                gate_reg    <= g_new[GATE_W-1:0];
                m_valid_reg <= 1'b1;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
        end
        if (cmd.decide) begin
            sym_reg  <= sym;
            code_reg <= code;
        end
    end

    assign m_valid         = m_valid_reg;
    assign m_symbol_value  = sym_reg;
    assign m_status        = code_reg;
    assign m_gate_position = gate_reg;

    assign status.last_sample = (cnt_reg == CNT_W'(N - 1));
    assign status.out_pending = m_valid_reg;
    assign status.n_last      = (n_reg == CNT_W'(N - 1));
    assign status.pipe_busy   = v1_reg | v2_reg;
    assign status.k_last      = (k_reg == BIN_W'(HALF_BINS - 1));
    assign status.pass_early  = pass_early_reg;
    assign status.sqrt_done   = root_done;
    assign status.gate_zero   = (gate_reg == '0);
    assign status.copy_last   = (GATE_W'(n_reg) == gate_reg - GATE_W'(1));

    a_gate_range: assert property (@(posedge aclk) disable iff (!aresetn)
        gate_reg <= GATE_W'(N)) else $error("gate beyond block length");

    a_result_free: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.decide |-> !m_valid_reg) else $error("result overwritten");

endmodule

>>> src/mfsk_ctrl.sv
// ----------------------------------------------------------------------------
// mfsk_ctrl
// Sequencer for sample intake, the two DFT passes, root, decision and tail copy.
// ----------------------------------------------------------------------------
module mfsk_ctrl
    import mfsk_pkg::*;
(
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       s_valid,
    output logic       s_ready,
    input  dp_status_t status,
    output ctrl_cmd_t  cmd
);

    ctrl_state_t state_reg, state_next;
    logic        ready;

    assign ready = (state_reg == S_IDLE) && !(status.last_sample && status.out_pending);

    always_comb begin
        state_next = state_reg;
        case (state_reg)
            S_IDLE: begin
                if (s_valid && ready && status.last_sample) state_next = S_MAC;
            end
            S_MAC: begin
                if (status.n_last) state_next = S_DRAIN;
            end
            S_DRAIN: begin
                if (!status.pipe_busy) state_next = S_SQUARE;
            end
            S_SQUARE: state_next = S_BIN;
            S_BIN: begin
                if (!status.k_last) state_next = S_MAC;
                else if (status.pass_early) state_next = S_SQRT_L_GO;
                else state_next = S_LATE_SAVE;
            end
            S_LATE_SAVE: state_next = S_MAC;
            S_SQRT_L_GO: state_next = S_SQRT_L_WAIT;
            S_SQRT_L_WAIT: begin
                if (status.sqrt_done) state_next = S_SQRT_E_GO;
            end
            S_SQRT_E_GO: state_next = S_SQRT_E_WAIT;
            S_SQRT_E_WAIT: begin
                if (status.sqrt_done) state_next = S_DECIDE;
            end
            S_DECIDE: state_next = S_COPY;
            S_COPY: begin
                if (status.gate_zero) state_next = S_IDLE;
                else if (status.copy_last) state_next = S_COPY_DRAIN;
            end
            S_COPY_DRAIN: state_next = S_IDLE;
            default: state_next = S_IDLE;
        endcase
    end

    always_comb begin
        cmd     = '0;
        s_ready = ready;
        case (state_reg)
            S_IDLE: begin
                cmd.wr_sample  = s_valid && ready;
                cmd.pass_start = s_valid && ready && status.last_sample;
            end
            S_MAC:         cmd.mac_issue = 1'b1;
            S_SQUARE:      cmd.square = 1'b1;
            S_BIN:         cmd.bin_done = 1'b1;
            S_LATE_SAVE:   cmd.late_save = 1'b1;
            S_SQRT_L_GO:   cmd.sqrt_start = 1'b1;
            S_SQRT_E_GO: begin
                cmd.sqrt_start = 1'b1;
                cmd.sqrt_sel   = 1'b1;
            end
            S_DECIDE:      cmd.decide = 1'b1;
            S_COPY:        cmd.copy_issue = !status.gate_zero;
            default:       cmd = '0;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= S_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    a_ready_idle: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg != S_IDLE) |-> !s_ready) else $error("sample taken while busy");

endmodule
